FILE: sv/bsc_pkg.sv
// bsc_pkg: shared types, register codes and constants of the barometric
// sensor compensation block. No dependencies.
`default_nettype none

package bsc_pkg;

  localparam int DIV_STEPS = 32;

  // configuration register indexes
  localparam logic [2:0] REG_OSS     = 3'd0;
  localparam logic [2:0] REG_AC1_AC2 = 3'd1;
  localparam logic [2:0] REG_AC3_AC4 = 3'd2;
  localparam logic [2:0] REG_AC5_AC6 = 3'd3;
  localparam logic [2:0] REG_B1_B2   = 3'd4;
  localparam logic [2:0] REG_MC_MD   = 3'd5;

  localparam logic [1:0] OSS_RESET = 2'd1;

  localparam logic signed [31:0] C_B6_OFFSET = 32'sd4000;
  localparam logic signed [31:0] C_P_X1      = 32'sd3038;
  localparam logic signed [31:0] C_P_X2      = -32'sd7357;
  localparam logic signed [31:0] C_P_OFFSET  = 32'sd3791;
  localparam logic signed [31:0] C_B4_OFFSET = 32'sd32768;
  localparam logic [15:0]        C_B7_SCALE  = 16'd50000;

  typedef struct packed {
    logic [1:0]  oss;
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } cfg_t;

  // item handed from the front end to the back end
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] den;
    logic [23:0]        up;
  } mid_t;

  // low 32 bits of a signed product
  function automatic logic signed [31:0] mulw(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] prod;
    prod = a * b;
    return prod[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/bsc_divider.sv
// bsc_divider: pipelined 32/32 unsigned restoring divider, one quotient
// bit per stage. Depends on bsc_pkg.
`default_nettype none

module bsc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        out_valid,
  output logic [31:0] quotient
);

  logic [31:0] rem  [bsc_pkg::DIV_STEPS];
  logic [31:0] quo  [bsc_pkg::DIV_STEPS];
  logic [31:0] dsr  [bsc_pkg::DIV_STEPS];
  logic        vld  [bsc_pkg::DIV_STEPS];
  logic [31:0] rem_next [bsc_pkg::DIV_STEPS];
  logic [31:0] quo_next [bsc_pkg::DIV_STEPS];

  always_comb begin
    logic [31:0] a_in;
    logic [31:0] q_in;
    logic [31:0] d_in;
    logic [32:0] trial;
    for (int k = 0; k < bsc_pkg::DIV_STEPS; k++) begin
      a_in = (k == 0) ? 32'd0 : rem[(k == 0) ? 0 : k - 1];
      q_in = (k == 0) ? dividend : quo[(k == 0) ? 0 : k - 1];
      d_in = (k == 0) ? divisor : dsr[(k == 0) ? 0 : k - 1];
      trial = {a_in, q_in[31]};
      if (trial >= {1'b0, d_in}) begin
        rem_next[k] = 32'(trial - {1'b0, d_in});
        quo_next[k] = {q_in[30:0], 1'b1};
      end else begin
        rem_next[k] = trial[31:0];
        quo_next[k] = {q_in[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bsc_pkg::DIV_STEPS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < bsc_pkg::DIV_STEPS; k++)
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < bsc_pkg::DIV_STEPS; k++) begin
        rem[k] <= rem_next[k];
        quo[k] <= quo_next[k];
        dsr[k] <= (k == 0) ? divisor : dsr[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_valid = vld[bsc_pkg::DIV_STEPS-1];
  assign quotient  = quo[bsc_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: sv/bsc_front.sv
// bsc_front: input stage; aligns the raw pressure and computes X1 and the
// temperature divisor. Depends on bsc_pkg.
`default_nettype none

module bsc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [15:0]      raw_temperature,
  input  logic [23:0]      raw_pressure,
  input  bsc_pkg::cfg_t    cfg,
  output logic             mid_push,
  output bsc_pkg::mid_t    mid_data,
  input  logic             mid_full
);

  logic        adv;
  logic        f0_valid;
  logic [15:0] f0_ut;
  logic [23:0] f0_up;
  logic        f1_valid;
  logic signed [31:0] f1_prod;
  logic [23:0] f1_up;
  logic signed [16:0] diff;
  logic signed [31:0] x1;

  assign adv      = !(f1_valid && mid_full);
  assign full     = !adv;
  assign mid_push = adv && f1_valid;

  assign diff = signed'({1'b0, f0_ut}) - signed'({1'b0, cfg.ac5_ac6[15:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
      f1_valid <= 1'b0;
    end else if (adv) begin
      f0_valid <= push;
      f1_valid <= f0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_ut   <= raw_temperature;
      f0_up   <= raw_pressure;
      f1_prod <= bsc_pkg::mulw(32'(diff), signed'({16'd0, cfg.ac5_ac6[31:16]}));
      f1_up   <= f0_up >> (4'd8 - {2'b00, cfg.oss});
    end
  end

  assign x1           = f1_prod >>> 15;
  assign mid_data.x1  = x1;
  assign mid_data.den = x1 + 32'(signed'(cfg.mc_md[15:0]));
  assign mid_data.up  = f1_up;

endmodule

`default_nettype wire

FILE: sv/bsc_queue.sv
// bsc_queue: two-entry queue between front and back ends.
// Depends on bsc_pkg.
`default_nettype none

module bsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bsc_pkg::mid_t wdata,
  output logic          full,
  input  logic          pop,
  output bsc_pkg::mid_t rdata,
  output logic          empty
);

  bsc_pkg::mid_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

FILE: sv/bsc_back.sv
// bsc_back: compensation pipeline with two divider units and the result
// queue. Depends on bsc_pkg and bsc_divider.
`default_nettype none

module bsc_back (
  input  logic          clk,
  input  logic          rst,
  input  bsc_pkg::cfg_t cfg,
  input  logic          mid_empty,
  input  bsc_pkg::mid_t mid_data,
  output logic          mid_pop,
  output logic          empty,
  input  logic          pop,
  output logic signed [15:0] temperature_tenths,
  output logic signed [31:0] pressure_pascal,
  output logic          divide_error
);

  typedef struct packed {
    logic signed [31:0] x1;
    logic [23:0]        up;
    logic               dz;
    logic               qneg;
  } side1_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic               err;
    logic               dbl;
  } side2_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic signed [31:0] p;
    logic               err;
  } res_t;

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc;
  logic [15:0] ac4;
  logic [15:0] b7_scale;

  assign ac1 = 32'(signed'(cfg.ac1_ac2[31:16]));
  assign ac2 = 32'(signed'(cfg.ac1_ac2[15:0]));
  assign ac3 = 32'(signed'(cfg.ac3_ac4[31:16]));
  assign ac4 = cfg.ac3_ac4[15:0];
  assign b1  = 32'(signed'(cfg.b1_b2[31:16]));
  assign b2  = 32'(signed'(cfg.b1_b2[15:0]));
  assign mc  = 32'(signed'(cfg.mc_md[31:16]));
  assign b7_scale = bsc_pkg::C_B7_SCALE >> cfg.oss;

  logic adv;
  logic rq_full;
  logic g5_valid;

  assign adv     = !(g5_valid && rq_full);
  assign mid_pop = adv && !mid_empty;

  // D0: magnitudes for the signed division
  logic               d0_valid;
  logic [31:0]        d0_num, d0_den;
  side1_t             d0_side;
  logic signed [31:0] num;

  assign num = mc <<< 11;

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_num       <= num[31] ? 32'(-num) : num;
      d0_den       <= mid_data.den[31] ? 32'(-mid_data.den) : mid_data.den;
      d0_side.x1   <= mid_data.x1;
      d0_side.up   <= mid_data.up;
      d0_side.dz   <= (mid_data.den == 32'sd0);
      d0_side.qneg <= num[31] ^ mid_data.den[31];
    end
  end

  logic        div1_valid;
  logic [31:0] div1_q;
  side1_t      s1 [bsc_pkg::DIV_STEPS];

  bsc_divider u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d0_valid),
    .dividend  (d0_num),
    .divisor   (d0_den),
    .out_valid (div1_valid),
    .quotient  (div1_q)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < bsc_pkg::DIV_STEPS; k++)
        s1[k] <= (k == 0) ? d0_side : s1[(k == 0) ? 0 : k - 1];
    end
  end

  side1_t s1_out;
  assign s1_out = s1[bsc_pkg::DIV_STEPS-1];

  // E stages
  logic e1_v, e2_v, e3_v, e4_v, e5_v, e6_v, e7_v, e8_v, e9_v, e10_v;
  logic signed [31:0] e1_b5, e1_b6;
  logic [23:0] e1_up, e2_up, e3_up, e4_up, e5_up, e6_up, e7_up;
  logic e1_dz, e2_dz, e3_dz, e4_dz, e5_dz, e6_dz, e7_dz, e8_dz, e9_dz;
  logic signed [15:0] e2_t, e3_t, e4_t, e5_t, e6_t, e7_t, e8_t, e9_t;
  logic signed [31:0] e2_bb, e2_a2, e2_a3;
  logic signed [31:0] e3_sq, e3_xa2, e3_xc1;
  logic signed [31:0] e4_m2, e4_m1, e4_xa2, e4_xc1;
  logic signed [31:0] e5_x3, e5_x3b;
  logic signed [31:0] e6_s, e6_xb;
  logic signed [31:0] e7_b3;
  logic [31:0] e7_mb4;
  logic [31:0] e8_b4, e8_diff;
  logic [31:0] e9_b4, e9_b7;
  logic [31:0] e10_num, e10_b4;
  side2_t      e10_side;

  logic signed [31:0] x2_c, b5_c, tv_c, u_c;
  logic [47:0] mb4_c, b7_c;

  assign x2_c  = s1_out.qneg ? 32'(-signed'(div1_q)) : signed'(div1_q);
  assign b5_c  = s1_out.x1 + x2_c;
  assign tv_c  = (e1_b5 + 32'sd8) >>> 4;
  assign u_c   = e6_s + 32'sd2;
  assign mb4_c = 48'(ac4) * 48'(unsigned'(e6_xb));
  assign b7_c  = 48'(e8_diff) * 48'(b7_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      {d0_valid, e1_v, e2_v, e3_v, e4_v, e5_v, e6_v, e7_v, e8_v, e9_v, e10_v} <= '0;
    end else if (adv) begin
      d0_valid <= !mid_empty;
      e1_v  <= div1_valid;
      e2_v  <= e1_v;
      e3_v  <= e2_v;
      e4_v  <= e3_v;
      e5_v  <= e4_v;
      e6_v  <= e5_v;
      e7_v  <= e6_v;
      e8_v  <= e7_v;
      e9_v  <= e8_v;
      e10_v <= e9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_b5 <= b5_c;
      e1_b6 <= b5_c - bsc_pkg::C_B6_OFFSET;
      e1_up <= s1_out.up;
      e1_dz <= s1_out.dz;

      if (tv_c > 32'sd32767)       e2_t <= 16'sh7fff;
      else if (tv_c < -32'sd32768) e2_t <= -16'sh8000;
      else                         e2_t <= tv_c[15:0];
      e2_bb <= bsc_pkg::mulw(e1_b6, e1_b6);
      e2_a2 <= bsc_pkg::mulw(ac2, e1_b6);
      e2_a3 <= bsc_pkg::mulw(ac3, e1_b6);
      e2_up <= e1_up;
      e2_dz <= e1_dz;

      e3_sq  <= e2_bb >>> 12;
      e3_xa2 <= e2_a2 >>> 11;
      e3_xc1 <= e2_a3 >>> 13;
      e3_t   <= e2_t;
      e3_up  <= e2_up;
      e3_dz  <= e2_dz;

      e4_m2  <= bsc_pkg::mulw(b2, e3_sq);
      e4_m1  <= bsc_pkg::mulw(b1, e3_sq);
      e4_xa2 <= e3_xa2;
      e4_xc1 <= e3_xc1;
      e4_t   <= e3_t;
      e4_up  <= e3_up;
      e4_dz  <= e3_dz;

      e5_x3  <= (e4_m2 >>> 11) + e4_xa2;
      e5_x3b <= (e4_xc1 + (e4_m1 >>> 16) + 32'sd2) >>> 2;
      e5_t   <= e4_t;
      e5_up  <= e4_up;
      e5_dz  <= e4_dz;

      e6_s  <= ((ac1 <<< 2) + e5_x3) <<< cfg.oss;
      e6_xb <= e5_x3b + bsc_pkg::C_B4_OFFSET;
      e6_t  <= e5_t;
      e6_up <= e5_up;
      e6_dz <= e5_dz;

      // divide by four, truncating toward zero
      e7_b3  <= (u_c + (u_c[31] ? 32'sd3 : 32'sd0)) >>> 2;
      e7_mb4 <= mb4_c[31:0];
      e7_t   <= e6_t;
      e7_up  <= e6_up;
      e7_dz  <= e6_dz;

      e8_b4   <= e7_mb4 >> 15;
      e8_diff <= {8'd0, e7_up} - unsigned'(e7_b3);
      e8_t    <= e7_t;
      e8_dz   <= e7_dz;

      e9_b7 <= b7_c[31:0];
      e9_b4 <= e8_b4;
      e9_t  <= e8_t;
      e9_dz <= e8_dz;

      // top bit set: divide first, double afterwards
      e10_num      <= e9_b7[31] ? e9_b7 : {e9_b7[30:0], 1'b0};
      e10_b4       <= e9_b4;
      e10_side.dbl <= e9_b7[31];
      e10_side.err <= e9_dz || (e9_b4 == 32'd0);
      e10_side.t   <= e9_t;
    end
  end

  logic        div2_valid;
  logic [31:0] div2_q;
  side2_t      s2 [bsc_pkg::DIV_STEPS];

  bsc_divider u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (e10_v),
    .dividend  (e10_num),
    .divisor   (e10_b4),
    .out_valid (div2_valid),
    .quotient  (div2_q)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < bsc_pkg::DIV_STEPS; k++)
        s2[k] <= (k == 0) ? e10_side : s2[(k == 0) ? 0 : k - 1];
    end
  end

  side2_t s2_out;
  assign s2_out = s2[bsc_pkg::DIV_STEPS-1];

  // G stages: pressure correction
  logic g1_v, g2_v, g3_v, g4_v;
  logic signed [31:0] g1_p, g1_p8, g2_p, g2_m1, g2_m2, g3_p, g3_m3, g3_x2;
  logic signed [31:0] g4_p, g4_sum;
  side2_t g1_side, g2_side, g3_side, g4_side;
  res_t   g5_res;
  logic signed [31:0] p_c;

  assign p_c = signed'(s2_out.dbl ? {div2_q[30:0], 1'b0} : div2_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      {g1_v, g2_v, g3_v, g4_v, g5_valid} <= '0;
    end else if (adv) begin
      g1_v     <= div2_valid;
      g2_v     <= g1_v;
      g3_v     <= g2_v;
      g4_v     <= g3_v;
      g5_valid <= g4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_p    <= p_c;
      g1_p8   <= p_c >>> 8;
      g1_side <= s2_out;

      g2_m1   <= bsc_pkg::mulw(g1_p8, g1_p8);
      g2_m2   <= bsc_pkg::mulw(bsc_pkg::C_P_X2, g1_p);
      g2_p    <= g1_p;
      g2_side <= g1_side;

      g3_m3   <= bsc_pkg::mulw(g2_m1, bsc_pkg::C_P_X1);
      g3_x2   <= g2_m2 >>> 16;
      g3_p    <= g2_p;
      g3_side <= g2_side;

      g4_sum  <= (g3_m3 >>> 16) + g3_x2 + bsc_pkg::C_P_OFFSET;
      g4_p    <= g3_p;
      g4_side <= g3_side;

      g5_res.err <= g4_side.err;
      g5_res.t   <= g4_side.err ? 16'sd0 : g4_side.t;
      g5_res.p   <= g4_side.err ? 32'sd0 : g4_p + (g4_sum >>> 4);
    end
  end

  // result queue
  res_t       rq [2];
  logic       rq_wr, rq_rd;
  logic [1:0] rq_count;
  logic       rq_push, rq_pop;

  assign rq_full = (rq_count == 2'd2);
  assign empty   = (rq_count == 2'd0);
  assign rq_push = adv && g5_valid;
  assign rq_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (rq_push) rq_wr <= !rq_wr;
      if (rq_pop)  rq_rd <= !rq_rd;
      rq_count <= rq_count + 2'(rq_push) - 2'(rq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) rq[rq_wr] <= g5_res;
  end

  assign temperature_tenths = rq[rq_rd].t;
  assign pressure_pascal    = rq[rq_rd].p;
  assign divide_error       = rq[rq_rd].err;

endmodule

`default_nettype wire

FILE: sv/barometric_sensor_compensation.sv
// Top level: configuration registers, front end, mid queue and back end.
// Depends on bsc_pkg, bsc_front, bsc_queue and bsc_back.
`default_nettype none

// Takes one raw temperature/pressure sample per clock while full is low and
// returns one compensated result per sample, in order, through two front
// stages, the mid queue, a sign stage, a 32-stage divider for the temperature
// term, ten arithmetic stages, a 32-stage divider for pressure, five correction
// stages and the result queue. Both dividers are fully pipelined, so the
// sustained rate is one sample per cycle while the result side keeps popping.
// A zero divisor sets divide_error and zeroes both results. The user must write
// configuration only while no sample is in flight; the block does not check it.
module barometric_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] temperature_tenths,
  output logic signed [31:0] pressure_pascal,
  output logic               divide_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  bsc_pkg::cfg_t cfg;
  bsc_pkg::mid_t fq_data, qb_data;
  logic fq_push, fq_full, qb_pop, qb_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.oss     <= bsc_pkg::OSS_RESET;
      cfg.ac1_ac2 <= '0;
      cfg.ac3_ac4 <= '0;
      cfg.ac5_ac6 <= '0;
      cfg.b1_b2   <= '0;
      cfg.mc_md   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bsc_pkg::REG_OSS:     cfg.oss     <= cfg_data[1:0];
        bsc_pkg::REG_AC1_AC2: cfg.ac1_ac2 <= cfg_data;
        bsc_pkg::REG_AC3_AC4: cfg.ac3_ac4 <= cfg_data;
        bsc_pkg::REG_AC5_AC6: cfg.ac5_ac6 <= cfg_data;
        bsc_pkg::REG_B1_B2:   cfg.b1_b2   <= cfg_data;
        bsc_pkg::REG_MC_MD:   cfg.mc_md   <= cfg_data;
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .cfg             (cfg),
    .mid_push        (fq_push),
    .mid_data        (fq_data),
    .mid_full        (fq_full)
  );

  bsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (qb_pop),
    .rdata (qb_data),
    .empty (qb_empty)
  );

  bsc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .mid_empty          (qb_empty),
    .mid_data           (qb_data),
    .mid_pop            (qb_pop),
    .empty              (empty),
    .pop                (pop),
    .temperature_tenths (temperature_tenths),
    .pressure_pascal    (pressure_pascal),
    .divide_error       (divide_error)
  );

endmodule

`default_nettype wire

FILE: sv/bsc_checker.sv
// bsc_checker: port-level assertions for the compensation block, bound
// to the top level. Depends on barometric_sensor_compensation.
`default_nettype none

module bsc_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] temperature_tenths,
  input logic signed [31:0] pressure_pascal,
  input logic               divide_error
);

  // error results carry zeros
  a_err_zero: assert property (@(posedge clk)
    (!empty && divide_error) |-> (temperature_tenths == 16'sd0 &&
                                  pressure_pascal == 32'sd0))
    else $error("error result with nonzero fields");

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not clear after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(temperature_tenths) &&
                          $stable(pressure_pascal) && $stable(divide_error)))
    else $error("waiting result changed before transfer");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire
